@@ sv/wat_pkg.sv @@
// ----------------------------------------------------------------------------
// wat_pkg
// Shared types and constants for the window average threshold counter.
// ----------------------------------------------------------------------------
package wat_pkg;

  // Default sizes for the top-level parameters
  localparam int WINDOW_MAX_DEF  = 64;
  localparam int SAMPLE_BITS_DEF = 16;

  // Fixed field widths
  localparam int WS_W       = 7;
  localparam int THR_W      = 16;
  localparam int HIT_W      = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [HIT_W-1:0] HIT_MAX = {HIT_W{1'b1}};

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD   = 1'd1;

  // Entries in the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Classification of one queued word
  typedef struct packed {
    logic last;
    logic has_window;
  } job_flags_t;

  typedef enum logic {
    FR_IDLE,
    FR_CALC
  } front_state_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_CMP,
    BK_FIN
  } back_state_t;

endpackage

@@ sv/wat_ram.sv @@
// ----------------------------------------------------------------------------
// wat_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module wat_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, hold data between reads
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ sv/wat_front.sv @@
// ----------------------------------------------------------------------------
// wat_front
// Accepts samples, maintains the ring store and running window sum, and
// pushes one classified word per sample into the queue.
// ----------------------------------------------------------------------------
module wat_front #(
  parameter int WINDOW_MAX  = 64,
  parameter int SAMPLE_BITS = 16,
  localparam int SUM_W      = SAMPLE_BITS + $clog2(WINDOW_MAX),
  localparam int W_W        = $clog2(WINDOW_MAX + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          clear,
  input  logic [W_W-1:0]                win,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic                          last_sample,
  output logic                          job_push,
  input  logic                          job_full,
  output logic [SUM_W-1:0]              job_sum,
  output wat_pkg::job_flags_t           job_flags
);

  import wat_pkg::*;

  localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int IW = ((AW > W_W) ? AW : W_W) + 1;

  front_state_t state, state_next;

  logic signed [SAMPLE_BITS-1:0] sample_r;
  logic                          last_r;
  logic [AW-1:0]                 wp;
  logic [W_W-1:0]                seen;
  logic signed [SUM_W-1:0]       sum;

  logic                          accept;
  logic                          calc_go;
  logic [IW-1:0]                 diff;
  logic [AW-1:0]                 old_addr;
  logic [SAMPLE_BITS-1:0]        old_data;
  logic signed [SUM_W-1:0]       old_ext;
  logic signed [SUM_W-1:0]       sum_new;
  logic [W_W-1:0]                seen_new;
  logic                          has_window;

  assign in_ready = (state == FR_IDLE) && !rst;
  assign accept   = in_valid && in_ready;
  assign calc_go  = (state == FR_CALC) && !job_full;

  // Oldest sample of the window: wp - win, wrapped into the ring
  always_comb begin
    diff = IW'(wp) - IW'(win);
    if (diff[IW-1]) begin
      diff = diff + IW'(WINDOW_MAX);
    end
    old_addr = diff[AW-1:0];
  end

  wat_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (WINDOW_MAX)
  ) u_store (
    .clk   (clk),
    .we    (calc_go),
    .waddr (wp),
    .wdata (sample_r),
    .re    (accept),
    .raddr (old_addr),
    .rdata (old_data)
  );

  // Slide the window: drop the oldest sample once full, add the new one
  always_comb begin
    old_ext    = SUM_W'(signed'(old_data));
    sum_new    = sum - ((seen >= win) ? old_ext : '0) + SUM_W'(sample_r);
    seen_new   = (seen < W_W'(WINDOW_MAX)) ? seen + W_W'(1) : seen;
    has_window = (seen_new >= win);
  end

  assign job_push  = calc_go;
  assign job_sum   = sum_new;
  assign job_flags = '{last: last_r, has_window: has_window};

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FR_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      FR_IDLE: if (accept) state_next = FR_CALC;
      FR_CALC: if (!job_full) state_next = FR_IDLE;
    endcase
  end

  // Capture the incoming word
  always_ff @(posedge clk) begin
    if (accept) begin
      sample_r <= sample;
      last_r   <= last_sample;
    end
  end

  // Advance sequence state, clear at end of sequence or on window resize
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      wp   <= '0;
      seen <= '0;
      sum  <= '0;
    end else if (calc_go) begin
      if (last_r) begin
        wp   <= '0;
        seen <= '0;
        sum  <= '0;
      end else begin
        wp   <= (wp == AW'(WINDOW_MAX - 1)) ? '0 : wp + AW'(1);
        seen <= seen_new;
        sum  <= sum_new;
      end
    end
  end

endmodule

@@ sv/wat_queue.sv @@
// ----------------------------------------------------------------------------
// wat_queue
// Small register FIFO between the front and back parts.
// ----------------------------------------------------------------------------
module wat_queue #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entry [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign rdata = entry[rd_ptr];

  // Store pushed word
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= wdata;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

@@ sv/wat_back.sv @@
// ----------------------------------------------------------------------------
// wat_back
// Divides each window sum by the window size (restoring, one quotient bit
// per cycle), compares the average to the threshold, counts hits and
// delivers the count at the end of a sequence.
// ----------------------------------------------------------------------------
module wat_back #(
  parameter int WINDOW_MAX  = 64,
  parameter int SAMPLE_BITS = 16,
  localparam int SUM_W      = SAMPLE_BITS + $clog2(WINDOW_MAX),
  localparam int W_W        = $clog2(WINDOW_MAX + 1)
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               clear,
  input  logic [W_W-1:0]                     win,
  input  logic signed [wat_pkg::THR_W-1:0]   threshold,
  input  logic                               job_valid,
  output logic                               job_pop,
  input  logic [SUM_W-1:0]                   job_sum,
  input  wat_pkg::job_flags_t                job_flags,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [wat_pkg::HIT_W-1:0]          hit_count
);

  import wat_pkg::*;

  localparam int CW    = $clog2(SUM_W + 1);
  localparam int QW    = SUM_W + 1;
  localparam int CMP_W = (QW > THR_W) ? QW : THR_W;

  back_state_t state, state_next;

  logic                    neg;
  logic                    last_r;
  logic [CW-1:0]           cnt;
  logic [W_W-1:0]          rem;
  logic [SUM_W-1:0]        quo;
  logic [HIT_W-1:0]        hits;

  logic [SUM_W-1:0]        mag;
  logic [W_W:0]            trial;
  logic                    ge;
  logic [W_W-1:0]          rem_next;
  logic signed [QW-1:0]    q_signed;
  logic                    hit;
  logic                    slot_free;
  logic                    emit;

  // Magnitude of the incoming sum
  assign mag = job_sum[SUM_W-1] ? (~job_sum + SUM_W'(1)) : job_sum;

  // One restoring division step
  always_comb begin
    trial    = {rem, quo[SUM_W-1]};
    ge       = (trial >= {1'b0, win});
    rem_next = ge ? W_W'(trial - {1'b0, win}) : W_W'(trial);
  end

  // Apply the sign, truncating toward zero, and compare
  always_comb begin
    q_signed = neg ? -signed'({1'b0, quo}) : signed'({1'b0, quo});
    hit      = (CMP_W'(q_signed) >= CMP_W'(threshold));
  end

  assign slot_free = !out_valid || out_ready;
  assign emit      = (state == BK_FIN) && last_r && slot_free;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and queue pop
  always_comb begin
    state_next = state;
    job_pop    = 1'b0;
    unique case (state)
      BK_IDLE: begin
        if (job_valid) begin
          job_pop    = 1'b1;
          state_next = job_flags.has_window ? BK_DIV : BK_FIN;
        end
      end
      BK_DIV: begin
        if (cnt == CW'(1)) state_next = BK_CMP;
      end
      BK_CMP: begin
        state_next = BK_FIN;
      end
      BK_FIN: begin
        if (!last_r || slot_free) state_next = BK_IDLE;
      end
    endcase
  end

  // Divider datapath
  always_ff @(posedge clk) begin
    unique case (state)
      BK_IDLE: begin
        if (job_valid) begin
          neg    <= job_sum[SUM_W-1];
          last_r <= job_flags.last;
          quo    <= mag;
          rem    <= '0;
          cnt    <= CW'(SUM_W);
        end
      end
      BK_DIV: begin
        rem <= rem_next;
        quo <= {quo[SUM_W-2:0], ge};
        cnt <= cnt - CW'(1);
      end
      BK_CMP, BK_FIN: begin
      end
    endcase
  end

  // Hit counter: saturate, clear after delivery or on window resize
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      hits <= '0;
    end else if (state == BK_CMP && hit && hits != HIT_MAX) begin
      hits <= hits + HIT_W'(1);
    end else if (emit) begin
      hits <= '0;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      hit_count <= hits;
    end
  end

endmodule

@@ sv/window_average_threshold_counter.sv @@
// ----------------------------------------------------------------------------
// window_average_threshold_counter
// Sliding-window moving average compared to a threshold, hit count per sequence.
// ----------------------------------------------------------------------------
// Flow: the front accepts a sample in FR_IDLE and pushes it in FR_CALC, stalling
//   there while the queue is full; the back runs a sample that completes a window
//   through BK_IDLE, BK_DIV (one quotient bit per cycle), BK_CMP and BK_FIN, any other
//   through BK_IDLE and BK_FIN; hit_count is registered in BK_FIN of the last sample.
// Reset: synchronous; window_size = 1, threshold = 0, sequence state cleared.
//   The ring store is not cleared; only entries of the current sequence enter the sum.
module window_average_threshold_counter #(
  parameter int WINDOW_MAX  = wat_pkg::WINDOW_MAX_DEF,
  parameter int SAMPLE_BITS = wat_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [SAMPLE_BITS-1:0]       sample,
  input  logic                                last_sample,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [wat_pkg::HIT_W-1:0]           hit_count,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [wat_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [wat_pkg::CFG_DATA_W-1:0]      cfg_data
);

  import wat_pkg::*;

  localparam int SUM_W    = SAMPLE_BITS + $clog2(WINDOW_MAX);
  localparam int W_W      = $clog2(WINDOW_MAX + 1);
  localparam int WS_EXT_W = ((WS_W > W_W) ? WS_W : W_W) + 1;
  localparam int JOB_W    = SUM_W + $bits(job_flags_t);

  logic [WS_W-1:0]         window_size;
  logic signed [THR_W-1:0] threshold;
  logic [WS_EXT_W-1:0]     ws_ext;
  logic [W_W-1:0]          win;
  logic                    seq_clear;

  logic                    push;
  logic                    full;
  logic [SUM_W-1:0]        push_sum;
  job_flags_t              push_flags;
  logic                    pop;
  logic                    empty;
  logic [JOB_W-1:0]        pop_word;
  job_flags_t              pop_flags;

  // Configuration registers
  assign cfg_ready = !rst;
  assign seq_clear = cfg_valid && (cfg_index == REG_WINDOW_SIZE);

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= WS_W'(1);
      threshold   <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_WINDOW_SIZE: window_size <= cfg_data[WS_W-1:0];
        REG_THRESHOLD:   threshold   <= signed'(cfg_data[THR_W-1:0]);
      endcase
    end
  end

  // Effective window: zero means one, clamp to the ring depth
  always_comb begin
    ws_ext = WS_EXT_W'(window_size);
    if (ws_ext == '0) begin
      win = W_W'(1);
    end else if (ws_ext > WS_EXT_W'(WINDOW_MAX)) begin
      win = W_W'(WINDOW_MAX);
    end else begin
      win = W_W'(ws_ext);
    end
  end

  wat_front #(
    .WINDOW_MAX  (WINDOW_MAX),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .clear       (seq_clear),
    .win         (win),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .sample      (sample),
    .last_sample (last_sample),
    .job_push    (push),
    .job_full    (full),
    .job_sum     (push_sum),
    .job_flags   (push_flags)
  );

  wat_queue #(
    .WIDTH (JOB_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata ({push_flags, push_sum}),
    .full  (full),
    .pop   (pop),
    .rdata (pop_word),
    .empty (empty)
  );

  assign pop_flags = job_flags_t'(pop_word[JOB_W-1:SUM_W]);

  wat_back #(
    .WINDOW_MAX  (WINDOW_MAX),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .clear     (seq_clear),
    .win       (win),
    .threshold (threshold),
    .job_valid (!empty),
    .job_pop   (pop),
    .job_sum   (pop_word[SUM_W-1:0]),
    .job_flags (pop_flags),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .hit_count (hit_count)
  );

endmodule

@@ bench/tb_window_average_threshold_counter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_window_average_threshold_counter
// Self-checking bench for the moving-average threshold counter. Sample words
// go in over valid/ready with random gaps and output stalls. A local
// predictor tracks the window and the hit tally and queues the count due at
// each last word. Directed cases come first, then random sequences over many
// register settings.
// ----------------------------------------------------------------------------
module tb_window_average_threshold_counter;
  import wat_pkg::*;

  localparam int WIN_MAX      = WINDOW_MAX_DEF;
  localparam int SBITS        = SAMPLE_BITS_DEF;
  localparam int SUM_BITS     = 22;
  localparam int SETTLE       = 150;
  localparam int QUIET_LIMIT  = 2000;
  localparam int RANDOM_WORDS = 700;

  logic                    clk         = 1'b0;
  logic                    rst         = 1'b1;
  logic                    in_valid    = 1'b0;
  logic                    in_ready;
  logic signed [SBITS-1:0] sample      = '0;
  logic                    last_sample = 1'b0;
  logic                    out_valid;
  logic                    out_ready   = 1'b0;
  logic [HIT_W-1:0]        hit_count;
  logic                    cfg_valid   = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index   = REG_WINDOW_SIZE;
  logic [CFG_DATA_W-1:0]   cfg_data    = '0;

  // Predictor state
  logic signed [SBITS-1:0]    ring_mem [WIN_MAX];
  logic signed [SUM_BITS-1:0] win_sum;
  int unsigned                wr_ptr;
  int unsigned                fill;
  logic [HIT_W-1:0]           hit_tally;
  logic [WS_W-1:0]            win_cfg;
  logic signed [THR_W-1:0]    thr_cfg;
  logic [HIT_W-1:0]           counts_due [$];

  // Run bookkeeping
  bit          calm = 1'b0;
  int unsigned errors = 0;
  int unsigned words_sent = 0;
  int unsigned counts_checked = 0;
  int unsigned reg_writes = 0;
  int unsigned windows_formed = 0;
  int unsigned quiet = 0;
  logic [HIT_W-1:0] due_count;

  window_average_threshold_counter uut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .sample     (sample),
    .last_sample(last_sample),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .hit_count  (hit_count),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Window length actually used: zero acts as one, oversize clamps to the store
  function automatic int unsigned span_of(logic [WS_W-1:0] w);
    if (w == 0) return 1;
    if (w > WIN_MAX) return WIN_MAX;
    return w;
  endfunction

  function automatic void restart_sequence();
    win_sum   = '0;
    wr_ptr    = 0;
    fill      = 0;
    hit_tally = '0;
  endfunction

  // Push one word through the window, count a hit, queue the count on last
  function automatic void advance_window(logic signed [SBITS-1:0] s, logic is_last);
    int unsigned                span;
    int unsigned                oldest;
    logic signed [7:0]          divisor;
    logic signed [SUM_BITS-1:0] avg;
    span = span_of(win_cfg);
    if (fill >= span) begin
      oldest  = (wr_ptr + WIN_MAX - span) % WIN_MAX;
      win_sum = win_sum - ring_mem[oldest];
    end
    ring_mem[wr_ptr] = s;
    win_sum = win_sum + s;
    wr_ptr  = (wr_ptr + 1) % WIN_MAX;
    if (fill < WIN_MAX) fill++;
    if (fill >= span) begin
      divisor = 8'(span);
      // signed divide truncates toward zero
      avg = win_sum / divisor;
      windows_formed++;
      if (avg >= thr_cfg && hit_tally != HIT_MAX) hit_tally++;
    end
    if (is_last) begin
      counts_due = {counts_due, hit_tally};
      restart_sequence();
    end
  endfunction

  // Send one word; entered and left at a falling edge
  task automatic send_word(input logic signed [SBITS-1:0] s, input logic is_last);
    if (!calm && $urandom_range(99) < 8) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 30)) @(negedge clk);
    end
    in_valid    <= 1'b1;
    sample      <= s;
    last_sample <= is_last;
    do @(posedge clk); while (!in_ready);
    advance_window(s, is_last);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_WINDOW_SIZE) begin
      win_cfg = data[WS_W-1:0];
      restart_sequence();
    end else begin
      thr_cfg = signed'(data);
    end
    reg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Drop valid, let every due count arrive, then give the datapath time to empty
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (counts_due.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // Registers at reset values: window of one, threshold zero
  task automatic test_reset_defaults();
    send_word(-16'sd1, 1'b0);
    send_word(16'sd0, 1'b0);
    send_word(16'sd1, 1'b1);
    send_word(16'sd5, 1'b1);
  endtask

  // Negative sums must truncate toward zero, not floor
  task automatic test_truncation();
    wait_drained();
    write_reg(REG_WINDOW_SIZE, 16'd2);
    write_reg(REG_THRESHOLD, 16'd0);
    send_word(-16'sd1, 1'b0);
    send_word(16'sd0, 1'b0);
    send_word(-16'sd3, 1'b1);
  endtask

  // Full-scale samples against full-scale thresholds
  task automatic test_extremes();
    wait_drained();
    write_reg(REG_WINDOW_SIZE, 16'd3);
    write_reg(REG_THRESHOLD, 16'h7FFF);
    repeat (2) send_word(16'sh7FFF, 1'b0);
    send_word(16'sh7FFF, 1'b1);
    wait_drained();
    write_reg(REG_THRESHOLD, 16'h8000);
    repeat (2) send_word(16'sh8000, 1'b0);
    send_word(16'sh8000, 1'b1);
  endtask

  // Sequences that never fill the window report zero
  task automatic test_short_sequence();
    wait_drained();
    write_reg(REG_WINDOW_SIZE, 16'd4);
    send_word(16'sd100, 1'b0);
    send_word(16'sd100, 1'b1);
    send_word(16'sd100, 1'b1);
  endtask

  // Window size zero acts as one; oversize clamps to the store depth
  task automatic test_window_clamp();
    wait_drained();
    write_reg(REG_WINDOW_SIZE, 16'd0);
    write_reg(REG_THRESHOLD, 16'd8);
    send_word(16'sd7, 1'b0);
    send_word(16'sd9, 1'b1);
    wait_drained();
    write_reg(REG_WINDOW_SIZE, 16'd127);
    repeat (2) send_word(16'sd50, 1'b0);
    send_word(16'sd50, 1'b1);
  endtask

  // Window write restarts a half-done sequence; threshold write applies onward
  task automatic test_config_mid_sequence();
    wait_drained();
    write_reg(REG_WINDOW_SIZE, 16'd2);
    write_reg(REG_THRESHOLD, 16'd0);
    send_word(16'sd100, 1'b0);
    send_word(16'sd100, 1'b0);
    wait_drained();
    write_reg(REG_WINDOW_SIZE, 16'd2);
    send_word(16'sd5, 1'b1);
    send_word(16'sd10, 1'b0);
    send_word(16'sd10, 1'b0);
    wait_drained();
    write_reg(REG_THRESHOLD, 16'd11);
    send_word(16'sd10, 1'b1);
  endtask

  // Random settings, each followed by a few complete sequences
  task automatic test_random_sequences();
    int unsigned             start;
    int unsigned             span;
    int unsigned             runs;
    int unsigned             len;
    int unsigned             k;
    int unsigned             mode;
    int                      spread;
    int                      centre;
    int                      v;
    logic [WS_W-1:0]         win;
    logic [CFG_DATA_W-1:0]   win_word;
    logic [CFG_DATA_W-1:0]   thr;
    start = words_sent;
    while (words_sent - start < RANDOM_WORDS) begin
      wait_drained();
      calm = (words_sent - start) < 150;
      // pick a window: mostly small, sometimes full depth or out of range
      v = $urandom_range(99);
      if (v < 55)      win = WS_W'($urandom_range(1, 8));
      else if (v < 75) win = WS_W'($urandom_range(9, WIN_MAX - 1));
      else if (v < 85) win = WS_W'(WIN_MAX);
      else if (v < 92) win = '0;
      else             win = WS_W'($urandom_range(WIN_MAX + 1, 127));
      win_word = {($urandom_range(3) == 0) ? 9'($urandom) : 9'd0, win};
      v = $urandom_range(99);
      if (v < 10)      thr = 16'h8000;
      else if (v < 20) thr = 16'h7FFF;
      else if (v < 40) thr = 16'($urandom);
      else             thr = 16'(int'($urandom_range(0, 400)) - 200);
      if ($urandom_range(1)) begin
        write_reg(REG_WINDOW_SIZE, win_word);
        write_reg(REG_THRESHOLD, thr);
      end else begin
        write_reg(REG_THRESHOLD, thr);
        write_reg(REG_WINDOW_SIZE, win_word);
      end
      span   = span_of(win);
      centre = int'($signed(thr));
      runs   = (span >= 32) ? $urandom_range(1, 2) : $urandom_range(1, 4);
      repeat (runs) begin
        if ($urandom_range(99) < 15) len = $urandom_range(1, span);
        else                         len = span + $urandom_range(0, span + 10);
        mode   = $urandom_range(2);
        spread = $urandom_range(0, 300);
        for (k = 1; k <= len; k++) begin
          // full range, clustered near the threshold, or rail to rail
          if (mode == 0 || (mode == 1 && $urandom_range(99) < 5)) begin
            v = int'($signed(16'($urandom)));
          end else if (mode == 1) begin
            v = centre + int'($urandom_range(0, 2 * spread)) - spread;
            if (v > 32767) v = 32767;
            if (v < -32768) v = -32768;
          end else begin
            v = $urandom_range(1) ? 32767 : -32768;
          end
          send_word(16'(v), k == len);
        end
      end
    end
    calm = 1'b0;
  endtask

  // Output stalls
  always @(negedge clk) begin
    out_ready <= calm || ($urandom_range(99) >= 8);
  end

  // Compare each count against the oldest one due
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (counts_due.size() == 0) begin
        $error("hit_count: expected none, actual %0d", hit_count);
        errors++;
      end else begin
        due_count = counts_due.pop_front();
        counts_checked++;
        if (hit_count !== due_count) begin
          $error("hit_count: expected %0d, actual %0d", due_count, hit_count);
          errors++;
        end
      end
    end
  end

  // End the run if no word moves on any channel for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else if (quiet == QUIET_LIMIT) begin
      $display("Watchdog: no transfer for %0d cycles", QUIET_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    restart_sequence();
    win_cfg = WS_W'(1);
    thr_cfg = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_truncation();
    test_extremes();
    test_short_sequence();
    test_window_clamp();
    test_config_mid_sequence();
    test_random_sequences();
    wait_drained();

    $display("Sent %0d sample words over %0d register writes, %0d windows formed",
             words_sent, reg_writes, windows_formed);
    $display("Checked %0d hit counts across directed and random sequences, %0d mismatches",
             counts_checked, errors);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
